// File: rtl/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types and constants for the segment graph builder.
// ----------------------------------------------------------------------------
package sgb_pkg;

   localparam int MAX_VERTICES_DEFAULT = 256;
   localparam int MAX_EDGES_DEFAULT    = 1024;
   localparam int COORD_BITS_DEFAULT   = 24;

   localparam int SNAP_W        = 16;
   localparam logic [SNAP_W-1:0] SNAP_RESET = 16'd100;
   localparam int SNAP_SQ_W     = 2 * SNAP_W;
   localparam int EDGE_IDX_W    = 10;
   localparam int VERTEX_IDX_W  = 8;
   localparam int LENGTH_W      = 25;
   localparam int RAD_W         = 64;
   localparam int ROOT_W        = RAD_W / 2;
   localparam int REM_W         = ROOT_W + 3;
   localparam int SQRT_CNT_W    = $clog2(ROOT_W);
   localparam int SAT_W         = 67;

   typedef enum logic [1:0] {
      STATUS_ADDED       = 2'd0,
      STATUS_DEGENERATE  = 2'd1,
      STATUS_VERTEX_FULL = 2'd2,
      STATUS_EDGE_FULL   = 2'd3
   } status_code_type;

   typedef struct packed {
      logic            load;
      logic            diff_seg;
      logic            diff_probe;
      logic            square;
      logic            sum;
      logic            seg_latch;
      logic            sqrt_step;
      logic            search_start;
      logic            search_end;
      logic            idx_inc;
      logic            match;
      logic            wr_start;
      logic            wr_end;
      logic            set_code;
      status_code_type code;
      logic            publish;
   } cmd_type;

   typedef struct packed {
      logic dsq_lt;
      logic edge_full;
      logic idx_at_end;
      logic sqrt_last;
      logic sel_end;
      logic s_found;
      logic e_found;
      logic fits;
      logic out_free;
   } stat_type;

endpackage

// File: rtl/sgb_ram.sv
// ----------------------------------------------------------------------------
// sgb_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module sgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sgb_datapath.sv
// ----------------------------------------------------------------------------
// sgb_datapath
// Coordinates, vertex table, distance unit, square root unit and results.
// ----------------------------------------------------------------------------
module sgb_datapath #(
   parameter int MAX_V = sgb_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_E = sgb_pkg::MAX_EDGES_DEFAULT,
   parameter int C     = sgb_pkg::COORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sgb_pkg::cmd_type                  cmd,
   output sgb_pkg::stat_type                 stat,
   input  logic                              csr_wr_en,
   input  logic [sgb_pkg::SNAP_W-1:0]        csr_wr_data,
   input  logic signed [C-1:0]               req_start_x,
   input  logic signed [C-1:0]               req_start_y,
   input  logic signed [C-1:0]               req_end_x,
   input  logic signed [C-1:0]               req_end_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [sgb_pkg::EDGE_IDX_W-1:0]    rsp_edge_index,
   output logic [sgb_pkg::VERTEX_IDX_W-1:0]  rsp_start_vertex,
   output logic [sgb_pkg::VERTEX_IDX_W-1:0]  rsp_end_vertex,
   output logic                              rsp_start_created,
   output logic                              rsp_end_created,
   output logic [sgb_pkg::LENGTH_W-1:0]      rsp_edge_length
);

   localparam int VC_W  = $clog2(MAX_V + 1);
   localparam int VA_W  = $clog2(MAX_V);
   localparam int EC_W  = $clog2(MAX_E + 1);
   localparam int D_W   = C + 1;
   localparam int SQ_W  = 2 * D_W;
   localparam int SUM_W = SQ_W + 1;

   logic signed [C-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [sgb_pkg::SNAP_W-1:0]    snap_ff, snap_in;
   logic [sgb_pkg::SNAP_SQ_W-1:0] snap_sq_ff, snap_sq_in;
   logic [D_W-1:0]   dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [SUM_W-1:0] dsq_ff, dsq_in;
   logic [sgb_pkg::SAT_W-1:0] dsq_ext;
   logic [sgb_pkg::RAD_W-1:0] rad_ff, rad_in;
   logic [sgb_pkg::REM_W-1:0] rem_ff, rem_in, cand, trial;
   logic [sgb_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [sgb_pkg::SQRT_CNT_W-1:0] scnt_ff, scnt_in;
   logic [VC_W-1:0] idx_ff, idx_in, vcount_ff, vcount_in;
   logic [VC_W-1:0] s_idx_ff, s_idx_in, e_idx_ff, e_idx_in;
   logic [EC_W-1:0] ecount_ff, ecount_in;
   logic sel_end_ff, sel_end_in, s_found_ff, s_found_in, e_found_ff, e_found_in;
   sgb_pkg::status_code_type code_ff, code_in;
   logic [VC_W:0] need_total;
   logic signed [C-1:0] ax, ay, bx, by, ram_x, ram_y;
   logic signed [D_W-1:0] dxs, dys;
   logic [2*C-1:0] ram_q, ram_wdata;
   logic ram_we;
   logic added;
   logic [sgb_pkg::LENGTH_W-1:0] len_sat;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff;
   logic [sgb_pkg::EDGE_IDX_W-1:0]   rsp_edge_index_ff;
   logic [sgb_pkg::VERTEX_IDX_W-1:0] rsp_start_vertex_ff, rsp_end_vertex_ff;
   logic rsp_start_created_ff, rsp_end_created_ff;
   logic [sgb_pkg::LENGTH_W-1:0] rsp_edge_length_ff;

   // Vertex table, x in the upper half and y in the lower half.
   assign ram_we    = cmd.wr_start || cmd.wr_end;
   assign ram_wdata = cmd.wr_end ? {ex_ff, ey_ff} : {sx_ff, sy_ff};

   sgb_ram #(
      .WIDTH (2 * C),
      .DEPTH (MAX_V)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (vcount_ff[VA_W-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff[VA_W-1:0]),
      .rd_data (ram_q)
   );

   assign ram_x = ram_q[2*C-1:C];
   assign ram_y = ram_q[C-1:0];

   // Distance unit.
   assign ax = (cmd.diff_probe && sel_end_ff) ? ex_ff : sx_ff;
   assign ay = (cmd.diff_probe && sel_end_ff) ? ey_ff : sy_ff;
   assign bx = cmd.diff_seg ? ex_ff : ram_x;
   assign by = cmd.diff_seg ? ey_ff : ram_y;
   assign dxs = {ax[C-1], ax} - {bx[C-1], bx};
   assign dys = {ay[C-1], ay} - {by[C-1], by};
   assign dx_in = dxs[D_W-1] ? D_W'(-dxs) : D_W'(dxs);
   assign dy_in = dys[D_W-1] ? D_W'(-dys) : D_W'(dys);
   assign sqx_in = dx_ff * dx_ff;
   assign sqy_in = dy_ff * dy_ff;
   assign dsq_in = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
   assign dsq_ext = sgb_pkg::SAT_W'(dsq_in);
   assign rad_in = (|dsq_ext[sgb_pkg::SAT_W-1:sgb_pkg::RAD_W]) ?
                   '1 : dsq_ext[sgb_pkg::RAD_W-1:0];

   // Square root unit, one result bit per step.
   assign cand  = {rem_ff[sgb_pkg::REM_W-3:0], rad_ff[sgb_pkg::RAD_W-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      scnt_in = scnt_ff;
      if (cmd.seg_latch) begin
         rem_in  = '0;
         root_in = '0;
         scnt_in = '0;
      end else if (cmd.sqrt_step) begin
         scnt_in = scnt_ff + 1'b1;
         if (cand >= trial) begin
            rem_in  = cand - trial;
            root_in = {root_ff[sgb_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cand;
            root_in = {root_ff[sgb_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign len_sat = (|root_ff[sgb_pkg::ROOT_W-1:sgb_pkg::LENGTH_W]) ?
                    '1 : root_ff[sgb_pkg::LENGTH_W-1:0];

   // Search control.
   assign snap_in    = csr_wr_en ? csr_wr_data : snap_ff;
   assign snap_sq_in = snap_ff * snap_ff;
   assign sel_end_in = cmd.search_start ? 1'b0 : (cmd.search_end ? 1'b1 : sel_end_ff);
   assign idx_in     = (cmd.search_start || cmd.search_end) ? '0 :
                       (cmd.idx_inc ? idx_ff + 1'b1 : idx_ff);
   assign s_found_in = cmd.load ? 1'b0 : ((cmd.match && !sel_end_ff) ? 1'b1 : s_found_ff);
   assign e_found_in = cmd.load ? 1'b0 : ((cmd.match && sel_end_ff) ? 1'b1 : e_found_ff);
   assign s_idx_in   = (cmd.match && !sel_end_ff) ? idx_ff :
                       (cmd.wr_start ? vcount_ff : s_idx_ff);
   assign e_idx_in   = (cmd.match && sel_end_ff) ? idx_ff :
                       (cmd.wr_end ? vcount_ff : e_idx_ff);
   assign vcount_in  = ram_we ? vcount_ff + 1'b1 : vcount_ff;
   assign code_in    = cmd.set_code ? cmd.code : code_ff;
   assign added      = (code_ff == sgb_pkg::STATUS_ADDED);
   assign ecount_in  = (cmd.publish && added) ? ecount_ff + 1'b1 : ecount_ff;
   assign need_total = (VC_W + 1)'(vcount_ff) + (VC_W + 1)'(!s_found_ff)
                     + (VC_W + 1)'(!e_found_ff);
   assign rsp_valid_in = cmd.publish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_ff      <= sgb_pkg::SNAP_RESET;
         vcount_ff    <= '0;
         ecount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         snap_ff      <= snap_in;
         vcount_ff    <= vcount_in;
         ecount_ff    <= ecount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff      <= req_start_x;
         sy_ff      <= req_start_y;
         ex_ff      <= req_end_x;
         ey_ff      <= req_end_y;
         snap_sq_ff <= snap_sq_in;
      end
      if (cmd.diff_seg || cmd.diff_probe) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (cmd.square) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
      end
      if (cmd.sum || cmd.seg_latch) begin
         dsq_ff <= dsq_in;
      end
      if (cmd.seg_latch) begin
         rad_ff <= rad_in;
      end else if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[sgb_pkg::RAD_W-3:0], 2'b00};
      end
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      scnt_ff    <= scnt_in;
      idx_ff     <= idx_in;
      sel_end_ff <= sel_end_in;
      s_found_ff <= s_found_in;
      e_found_ff <= e_found_in;
      s_idx_ff   <= s_idx_in;
      e_idx_ff   <= e_idx_in;
      code_ff    <= code_in;
      if (cmd.publish) begin
         rsp_status_ff        <= code_ff;
         rsp_edge_length_ff   <= len_sat;
         rsp_edge_index_ff    <= added ? sgb_pkg::EDGE_IDX_W'(ecount_ff) : '0;
         rsp_start_vertex_ff  <= added ? sgb_pkg::VERTEX_IDX_W'(s_idx_ff) : '0;
         rsp_end_vertex_ff    <= added ? sgb_pkg::VERTEX_IDX_W'(e_idx_ff) : '0;
         rsp_start_created_ff <= added && !s_found_ff;
         rsp_end_created_ff   <= added && !e_found_ff;
      end
   end

   assign stat.dsq_lt     = sgb_pkg::SAT_W'(dsq_ff) < sgb_pkg::SAT_W'(snap_sq_ff);
   assign stat.edge_full  = (EC_W + 1)'(ecount_ff) >= (EC_W + 1)'(MAX_E);
   assign stat.idx_at_end = (idx_ff == vcount_ff);
   assign stat.sqrt_last  = (scnt_ff == '1);
   assign stat.sel_end    = sel_end_ff;
   assign stat.s_found    = s_found_ff;
   assign stat.e_found    = e_found_ff;
   assign stat.fits       = need_total <= (VC_W + 1)'(MAX_V);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_edge_index    = rsp_edge_index_ff;
   assign rsp_start_vertex  = rsp_start_vertex_ff;
   assign rsp_end_vertex    = rsp_end_vertex_ff;
   assign rsp_start_created = rsp_start_created_ff;
   assign rsp_end_created   = rsp_end_created_ff;
   assign rsp_edge_length   = rsp_edge_length_ff;

endmodule

// File: rtl/sgb_controller.sv
// ----------------------------------------------------------------------------
// sgb_controller
// Sequencer for segment length, vertex searches, appends and result hand-off.
// ----------------------------------------------------------------------------
module sgb_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output sgb_pkg::cmd_type  cmd,
   input  sgb_pkg::stat_type stat
);

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_SEG_DIFF = 14'b00000000000010,
      ST_SEG_SQ   = 14'b00000000000100,
      ST_SEG_SUM  = 14'b00000000001000,
      ST_SQRT     = 14'b00000000010000,
      ST_CHECK    = 14'b00000000100000,
      ST_READ     = 14'b00000001000000,
      ST_DIFF     = 14'b00000010000000,
      ST_SQ       = 14'b00000100000000,
      ST_SUM      = 14'b00001000000000,
      ST_CMP      = 14'b00010000000000,
      ST_FIT      = 14'b00100000000000,
      ST_WRITE    = 14'b01000000000000,
      ST_FINISH   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      cmd.code = sgb_pkg::STATUS_ADDED;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEG_DIFF;
            end
         end
         ST_SEG_DIFF: begin
            cmd.diff_seg = 1'b1;
            state_in     = ST_SEG_SQ;
         end
         ST_SEG_SQ: begin
            cmd.square = 1'b1;
            state_in   = ST_SEG_SUM;
         end
         ST_SEG_SUM: begin
            cmd.seg_latch = 1'b1;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (stat.sqrt_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.dsq_lt) begin
               cmd.set_code = 1'b1;
               cmd.code     = sgb_pkg::STATUS_DEGENERATE;
               state_in     = ST_FINISH;
            end else if (stat.edge_full) begin
               cmd.set_code = 1'b1;
               cmd.code     = sgb_pkg::STATUS_EDGE_FULL;
               state_in     = ST_FINISH;
            end else begin
               cmd.search_start = 1'b1;
               state_in         = ST_READ;
            end
         end
         ST_READ: begin
            if (stat.idx_at_end) begin
               if (stat.sel_end) begin
                  state_in = ST_FIT;
               end else begin
                  cmd.search_end = 1'b1;
               end
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff_probe = 1'b1;
            state_in       = ST_SQ;
         end
         ST_SQ: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (stat.dsq_lt) begin
               cmd.match = 1'b1;
               if (stat.sel_end) begin
                  state_in = ST_FIT;
               end else begin
                  cmd.search_end = 1'b1;
                  state_in       = ST_READ;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_FIT: begin
            cmd.set_code = 1'b1;
            if (!stat.fits) begin
               cmd.code = sgb_pkg::STATUS_VERTEX_FULL;
               state_in = ST_FINISH;
            end else if (!stat.s_found) begin
               cmd.wr_start = 1'b1;
               state_in     = ST_WRITE;
            end else if (!stat.e_found) begin
               cmd.wr_end = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WRITE: begin
            cmd.wr_end = !stat.e_found;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// File: rtl/segment_graph_builder_core.sv
// ----------------------------------------------------------------------------
// segment_graph_builder_core
// Builds a path graph from track segments with snapped shared vertices.
// ----------------------------------------------------------------------------
//  channel | ports  | direction | word
//  req     | valid/ready | in   | segment start and end points
//  rsp     | valid/ready | out  | status, indices, created flags, length
//  csr     | wr_en/data  | in   | snap distance
//
// The length comes from the one-bit-per-cycle square root. Each of the two
// searches then probes the stored vertices one at a time through the single
// vertex table read port, and the word ends by closing the searches and
// appending any new vertices.
// Reset restores the snap distance and clears the counts; the vertex table
// needs no clearing pass. A held result does not stop the next word from being
// taken, but that word then waits for the output register before it finishes.
module segment_graph_builder_core #(
   parameter int MAX_VERTICES = sgb_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_EDGES    = sgb_pkg::MAX_EDGES_DEFAULT,
   parameter int COORD_BITS   = sgb_pkg::COORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [sgb_pkg::SNAP_W-1:0]        csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COORD_BITS-1:0]      req_start_x,
   input  logic signed [COORD_BITS-1:0]      req_start_y,
   input  logic signed [COORD_BITS-1:0]      req_end_x,
   input  logic signed [COORD_BITS-1:0]      req_end_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [sgb_pkg::EDGE_IDX_W-1:0]    rsp_edge_index,
   output logic [sgb_pkg::VERTEX_IDX_W-1:0]  rsp_start_vertex,
   output logic [sgb_pkg::VERTEX_IDX_W-1:0]  rsp_end_vertex,
   output logic                              rsp_start_created,
   output logic                              rsp_end_created,
   output logic [sgb_pkg::LENGTH_W-1:0]      rsp_edge_length
);

   sgb_pkg::cmd_type  cmd;
   sgb_pkg::stat_type stat;

   sgb_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   sgb_datapath #(
      .MAX_V (MAX_VERTICES),
      .MAX_E (MAX_EDGES),
      .C     (COORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_edge_index    (rsp_edge_index),
      .rsp_start_vertex  (rsp_start_vertex),
      .rsp_end_vertex    (rsp_end_vertex),
      .rsp_start_created (rsp_start_created),
      .rsp_end_created   (rsp_end_created),
      .rsp_edge_length   (rsp_edge_length)
   );

endmodule

// File: rtl/sgb_checker.sv
// ----------------------------------------------------------------------------
// sgb_checker
// Port level checks for the segment graph builder, bound to the top level.
// ----------------------------------------------------------------------------
module sgb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [1:0]                        rsp_status,
   input logic [sgb_pkg::VERTEX_IDX_W-1:0]  rsp_start_vertex,
   input logic [sgb_pkg::VERTEX_IDX_W-1:0]  rsp_end_vertex,
   input logic                              rsp_start_created,
   input logic                              rsp_end_created
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("Result word changed while stalled.");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sgb_pkg::STATUS_ADDED) |->
      !rsp_start_created && !rsp_end_created && rsp_start_vertex == '0 &&
      rsp_end_vertex == '0)
      else $error("Failed word carries vertex data.");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Input taken while a word is in progress.");

   a_both_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_created && rsp_end_created |->
      rsp_end_vertex == rsp_start_vertex + 1'b1)
      else $error("Two new vertices are not consecutive.");

endmodule

bind segment_graph_builder_core sgb_checker u_sgb_checker (.*);
